>>> src/evhp_pkg.sv
// shared types and constants for the ethernet vlan header parser
`default_nettype none

package evhp_pkg;

    localparam int ADDR_BYTES = 6;
    localparam int MAC_W = 8 * ADDR_BYTES;
    localparam int TDATA_W = 144;

    localparam logic [15:0] TAG_TYPE = 16'h8100;
    localparam logic [15:0] LENGTH_LIMIT_RST = 16'd1500;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } beat_t;

    typedef struct packed {
        logic             header_valid;
        logic [MAC_W-1:0] dst_mac;
        logic [MAC_W-1:0] src_mac;
        logic [15:0]      ether_type;
        logic             vlan_present;
        logic [2:0]       priority_res;
        logic             drop_eligible;
        logic [11:0]      vlan_id;
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             payload_last;
    } result_t;

endpackage

`default_nettype wire

>>> src/evhp_in_reg.sv
// input register stage for received frame beats
`default_nettype none

module evhp_in_reg (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  evhp_pkg::beat_t     s_beat,
    output logic                q_valid,
    output evhp_pkg::beat_t     q_beat,
    input  wire                 advance
);
    import evhp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;
    assign q_valid = valid_reg;
    assign q_beat  = beat_reg;

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take) begin
            beat_reg <= s_beat;
        end
    end

endmodule

`default_nettype wire

>>> src/evhp_core.sv
// header parse state and per-beat decode logic
`default_nettype none

module evhp_core (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  step,
    input  evhp_pkg::beat_t      beat,
    input  wire [15:0]           length_limit,
    output evhp_pkg::result_t    res
);
    import evhp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_COUNTED,
        PH_OPEN,
        PH_PADDING
    } phase_t;

    localparam logic [4:0] SRC_POS    = 5'(ADDR_BYTES);
    localparam logic [4:0] TYPE_POS   = 5'(2 * ADDR_BYTES);
    localparam logic [4:0] TYPE_LAST  = 5'(2 * ADDR_BYTES + 1);
    localparam logic [4:0] TAG_POS    = 5'(2 * ADDR_BYTES + 2);
    localparam logic [4:0] INNER_POS  = 5'(2 * ADDR_BYTES + 4);
    localparam logic [4:0] INNER_LAST = 5'(2 * ADDR_BYTES + 5);

    phase_t           phase_reg, phase_next, ph;
    logic [4:0]       pos_reg, pos_next, pos;
    logic [MAC_W-1:0] dst_reg, dst_next, dst;
    logic [MAC_W-1:0] src_reg, src_next, src;
    logic [15:0]      type_reg, type_next, typ;
    logic [15:0]      tag_reg, tag_next, tag;
    logic             tagged_reg, tagged_next, is_tagged;
    logic [15:0]      left_reg, left_next, left;
    logic [15:0]      left_dec;
    logic             done;

    // start of frame clears the parse context
    always_comb begin
        if (beat.frame_start) begin
            ph        = PH_HEADER;
            pos       = '0;
            dst       = '0;
            src       = '0;
            typ       = '0;
            tag       = '0;
            is_tagged = 1'b0;
            left      = '0;
        end else begin
            ph        = phase_reg;
            pos       = pos_reg;
            dst       = dst_reg;
            src       = src_reg;
            typ       = type_reg;
            tag       = tag_reg;
            is_tagged = tagged_reg;
            left      = left_reg;
        end
    end

    assign left_dec = left - 16'd1;

    always_comb begin
        phase_next  = ph;
        pos_next    = pos;
        dst_next    = dst;
        src_next    = src;
        type_next   = typ;
        tag_next    = tag;
        tagged_next = is_tagged;
        left_next   = left;
        done        = 1'b0;
        res         = '0;

        unique case (ph)
            PH_HEADER: begin
                if (pos < SRC_POS) begin
                    dst_next = {dst[MAC_W-9:0], beat.data_byte};
                end else if (pos < TYPE_POS) begin
                    src_next = {src[MAC_W-9:0], beat.data_byte};
                end else if (pos < TAG_POS) begin
                    type_next = {typ[7:0], beat.data_byte};
                    if (pos == TYPE_LAST) begin
                        if (type_next == TAG_TYPE) begin
                            tagged_next = 1'b1;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end else if (pos < INNER_POS) begin
                    tag_next = {tag[7:0], beat.data_byte};
                end else begin
                    type_next = {typ[7:0], beat.data_byte};
                    if (pos >= INNER_LAST) begin
                        done = 1'b1;
                    end
                end
                pos_next = pos + 5'd1;

                if (done) begin
                    res.header_valid = 1'b1;
                    res.dst_mac      = dst_next;
                    res.src_mac      = src_next;
                    res.ether_type   = type_next;
                    if (tagged_next) begin
                        res.vlan_present  = 1'b1;
                        res.priority_res  = tag_next[15:13];
                        res.drop_eligible = tag_next[12];
                        res.vlan_id       = tag_next[11:0];
                    end
                    if (type_next <= length_limit) begin
                        left_next  = type_next;
                        phase_next = (type_next == 16'd0) ? PH_PADDING : PH_COUNTED;
                    end else begin
                        left_next  = '0;
                        phase_next = PH_OPEN;
                    end
                end
                if (beat.frame_end) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_COUNTED: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = beat.data_byte;
                res.payload_last  = (left_dec == 16'd0) || beat.frame_end;
                left_next         = left_dec;
                if (beat.frame_end) begin
                    phase_next = PH_IDLE;
                end else if (left_dec == 16'd0) begin
                    phase_next = PH_PADDING;
                end
            end
            PH_OPEN: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = beat.data_byte;
                if (beat.frame_end) begin
                    res.payload_last = 1'b1;
                    phase_next       = PH_IDLE;
                end
            end
            PH_PADDING: begin
                if (beat.frame_end) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            tagged_reg <= 1'b0;
            left_reg   <= '0;
            dst_reg    <= '0;
            src_reg    <= '0;
            type_reg   <= '0;
            tag_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tagged_reg <= tagged_next;
            left_reg   <= left_next;
            dst_reg    <= dst_next;
            src_reg    <= src_next;
            type_reg   <= type_next;
            tag_reg    <= tag_next;
        end
    end

endmodule

`default_nettype wire

>>> src/evhp_out_reg.sv
// result register stage toward the output channel
`default_nettype none

module evhp_out_reg (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  load,
    input  evhp_pkg::result_t    d_res,
    output logic                 free,
    output logic                 m_valid,
    input  wire                  m_ready,
    output evhp_pkg::result_t    m_res
);
    import evhp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            res_reg <= d_res;
        end
    end

endmodule

`default_nettype wire

>>> src/ethernet_vlan_header_parser.sv
// top level of the ethernet / 802.1q receive header parser
//
// channel   direction  tdata                      tuser / tlast
// s_        in         data_byte                  frame_start / frame_end
// m_        out        header and payload fields  header_valid, payload_valid / payload_last
// cfg_wr_   in         length_limit               -
//
// one beat per cycle unless m_tready stalls; each beat gives exactly one result beat
// each beat passes the input register, then is decoded into the result register
// reset is synchronous active low; length_limit returns to 1500
// a stall on m_tready holds the result and drops s_tready in the same cycle once the
// input register holds a beat
`default_nettype none

module ethernet_vlan_header_parser (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [7:0]                          s_tdata,  // data_byte
    input  wire                                 s_tuser,  // frame_start
    input  wire                                 s_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // dst_mac, src_mac, ether_type, vlan_present, priority_res, drop_eligible,
    // vlan_id, payload_byte, zero fill
    output logic [evhp_pkg::TDATA_W-1:0]        m_tdata,
    output logic [1:0]                          m_tuser,  // header_valid, payload_valid
    output logic                                m_tlast,
    input  wire                                 cfg_wr_en,
    input  wire  [15:0]                         cfg_wr_data
);
    import evhp_pkg::*;

    logic [15:0] limit_reg;
    beat_t       s_beat;
    beat_t       q_beat;
    logic        q_valid;
    logic        out_free;
    logic        advance;
    result_t     core_res;
    result_t     m_res;

    assign s_beat.data_byte   = s_tdata;
    assign s_beat.frame_start = s_tuser;
    assign s_beat.frame_end   = s_tlast;

    assign advance = q_valid && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LENGTH_LIMIT_RST;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    evhp_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_beat  (s_beat),
        .q_valid (q_valid),
        .q_beat  (q_beat),
        .advance (advance)
    );

    evhp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .beat         (q_beat),
        .length_limit (limit_reg),
        .res          (core_res)
    );

    evhp_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .d_res   (core_res),
        .free    (out_free),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    assign m_tdata = {7'd0, m_res.payload_byte, m_res.vlan_id, m_res.drop_eligible,
                      m_res.priority_res, m_res.vlan_present, m_res.ether_type,
                      m_res.src_mac, m_res.dst_mac};
    assign m_tuser = {m_res.payload_valid, m_res.header_valid};
    assign m_tlast = m_res.payload_last;

endmodule

`default_nettype wire
